// File: rtl/core/gsdc_pkg.sv
package gsdc_pkg;

  localparam int TIME_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int STEPS_W     = 12;
  localparam int POS_W       = 13;
  localparam int SPEED_W     = 10;
  localparam int INTERVAL_W  = 6;
  localparam int PROD_W      = SPEED_W + INTERVAL_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DELAY_W-1:0]    DELAY_RESET   = DELAY_W'(50);
  localparam logic [STEPS_W-1:0]    STEPS_RESET   = STEPS_W'(258);
  localparam logic [POS_W-1:0]      POS_RESET     = POS_W'(258);
  localparam logic [1:0]            PHASE_RESET   = 2'd3;
  localparam logic [INTERVAL_W-1:0] INTERVAL_BASE = INTERVAL_W'(5);
  localparam logic [PROD_W-1:0]     SPEED_SCALE   = PROD_W'(50);

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_DELAY = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_STEPS     = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_BACK = 2'd2
  } mode_t;

  // one-hot wave drive, indexed by phase
  localparam logic [3:0] COIL_FWD  [4] = '{4'b0001, 4'b0010, 4'b0100, 4'b1000};
  localparam logic [3:0] COIL_BACK [4] = '{4'b1000, 4'b0100, 4'b0010, 4'b0001};

endpackage

// File: rtl/core/gsdc_tick_if.sv
interface gsdc_tick_if;
  import gsdc_pkg::*;

  logic               valid;
  logic               ready;
  logic               button_a_level;
  logic               button_b_level;
  logic [SPEED_W-1:0] speed_sample;

  modport source (output valid, output button_a_level, output button_b_level,
                  output speed_sample, input ready);
  modport sink   (input valid, input button_a_level, input button_b_level,
                  input speed_sample, output ready);
endinterface

// File: rtl/core/gsdc_drive_if.sv
interface gsdc_drive_if;
  import gsdc_pkg::*;

  logic             valid;
  logic             ready;
  logic [3:0]       coil_pattern;
  logic             forward_lamp;
  logic             backward_lamp;
  logic [POS_W-1:0] position;
  logic [1:0]       motion_mode;

  modport source (output valid, output coil_pattern, output forward_lamp,
                  output backward_lamp, output position, output motion_mode, input ready);
  modport sink   (input valid, input coil_pattern, input forward_lamp,
                  input backward_lamp, input position, input motion_mode, output ready);
endinterface

// File: rtl/core/gate_stepper_debounce_controller_core.sv
// Channel  Dir  Beat contents
// tick     in   button_a_level, button_b_level, speed_sample (one ms tick)
// drive    out  coil_pattern, forward_lamp, backward_lamp, position, motion_mode
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One tick beat per cycle while no drive beat is stalled; its drive beat appears the cycle after acceptance.
// The controller state registers are the drive payload; drive.valid marks it.
// tick.ready is high while no drive beat is pending or it is taken this cycle.
// Synchronous active-high rst loads the register defaults; no clearing pass.
module gate_stepper_debounce_controller_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gsdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gsdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  gsdc_tick_if.sink                        tick,
  gsdc_drive_if.source                     drive
);
  import gsdc_pkg::*;

  logic [DELAY_W-1:0] debounce_delay;
  logic [STEPS_W-1:0] full_steps;

  logic [TIME_W-1:0]  tick_time;
  logic               last_raw_a, stable_a, last_raw_b, stable_b;
  logic [TIME_W-1:0]  change_time_a, change_time_b;
  mode_t              mode_reg;
  logic [TIME_W-1:0]  step_start_time;
  logic [1:0]         phase_index;
  logic [POS_W-1:0]   step_position;
  logic [3:0]         coil_reg;
  logic [1:0]         lamp_toggles;
  logic [1:0]         lamp_pins;
  logic               out_valid;

  logic               tick_acc;
  logic [TIME_W-1:0]  now;
  logic [TIME_W-1:0]  change_time_a_next, change_time_b_next;
  logic               stable_a_next, stable_b_next;
  logic               press_a, press_b;
  mode_t              mode_next;
  logic [PROD_W-1:0]  speed_prod;
  logic [INTERVAL_W-1:0] interval;
  logic               move;
  logic               step_due;
  logic [1:0]         phase_next;
  logic [1:0]         lamp_toggles_next;
  logic [1:0]         lamp_pins_next;
  logic [POS_W-1:0]   step_position_next;
  logic [3:0]         coil_next;

  assign tick.ready = !out_valid || drive.ready;
  assign tick_acc   = tick.valid && tick.ready;
  assign now        = tick_time + TIME_W'(1);

  always_comb begin
    change_time_a_next = (tick.button_a_level != last_raw_a) ? now : change_time_a;
    change_time_b_next = (tick.button_b_level != last_raw_b) ? now : change_time_b;
    stable_a_next = stable_a;
    stable_b_next = stable_b;
    press_a = 1'b0;
    press_b = 1'b0;
    if ((now - change_time_a_next) > TIME_W'(debounce_delay) &&
        tick.button_a_level != stable_a) begin
      stable_a_next = tick.button_a_level;
      press_a = tick.button_a_level;
    end
    if ((now - change_time_b_next) > TIME_W'(debounce_delay) &&
        tick.button_b_level != stable_b) begin
      stable_b_next = tick.button_b_level;
      press_b = tick.button_b_level;
    end
  end

  // A steps toward forward, B toward backward; both together cancel
  always_comb begin
    mode_next = mode_reg;
    if (press_a && !press_b) begin
      unique case (mode_reg)
        MODE_BACK: mode_next = MODE_STOP;
        default:   mode_next = MODE_FWD;
      endcase
    end else if (press_b && !press_a) begin
      unique case (mode_reg)
        MODE_FWD: mode_next = MODE_STOP;
        default:  mode_next = MODE_BACK;
      endcase
    end
  end

  assign speed_prod = PROD_W'(tick.speed_sample) * SPEED_SCALE;
  assign interval   = speed_prod[PROD_W-1:SPEED_W] + INTERVAL_BASE;

  always_comb begin
    unique case (mode_next)
      MODE_FWD:  move = step_position <= POS_W'(full_steps);
      MODE_BACK: move = step_position != '0;
      default:   move = 1'b0;
    endcase
    step_due = move && ((now - step_start_time) >= TIME_W'(interval));
  end

  always_comb begin
    phase_next         = phase_index + 2'd1;
    lamp_toggles_next  = lamp_toggles;
    lamp_pins_next     = lamp_pins;
    step_position_next = step_position;
    coil_next          = coil_reg;
    if (mode_next == MODE_STOP) begin
      lamp_pins_next = 2'b00;
    end else if (step_due) begin
      if (mode_next == MODE_FWD) begin
        step_position_next   = step_position + POS_W'(1);
        lamp_toggles_next[0] = !lamp_toggles[0];
        lamp_pins_next[0]    = !lamp_toggles[0];
        coil_next            = COIL_FWD[phase_next];
      end else begin
        step_position_next   = step_position - POS_W'(1);
        lamp_toggles_next[1] = !lamp_toggles[1];
        lamp_pins_next[1]    = !lamp_toggles[1];
        coil_next            = COIL_BACK[phase_next];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_delay  <= DELAY_RESET;
      full_steps      <= STEPS_RESET;
      tick_time       <= '0;
      last_raw_a      <= 1'b0;
      stable_a        <= 1'b0;
      change_time_a   <= '0;
      last_raw_b      <= 1'b0;
      stable_b        <= 1'b0;
      change_time_b   <= '0;
      mode_reg        <= MODE_STOP;
      step_start_time <= '0;
      phase_index     <= PHASE_RESET;
      step_position   <= POS_RESET;
      coil_reg        <= '0;
      lamp_toggles    <= '0;
      lamp_pins       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEBOUNCE_DELAY: debounce_delay <= cfg_data[DELAY_W-1:0];
          REG_FULL_STEPS: begin
            full_steps    <= cfg_data[STEPS_W-1:0];
            step_position <= POS_W'(cfg_data[STEPS_W-1:0]);
          end
          default: ;
        endcase
      end
      if (tick_acc) begin
        tick_time     <= now;
        last_raw_a    <= tick.button_a_level;
        stable_a      <= stable_a_next;
        change_time_a <= change_time_a_next;
        last_raw_b    <= tick.button_b_level;
        stable_b      <= stable_b_next;
        change_time_b <= change_time_b_next;
        mode_reg      <= mode_next;
        lamp_pins     <= lamp_pins_next;
        if (step_due) begin
          step_start_time <= now;
          phase_index     <= phase_next;
          step_position   <= step_position_next;
          coil_reg        <= coil_next;
          lamp_toggles    <= lamp_toggles_next;
        end
        out_valid <= 1'b1;
      end else if (drive.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign drive.valid         = out_valid;
  assign drive.coil_pattern  = coil_reg;
  assign drive.forward_lamp  = lamp_pins[0];
  assign drive.backward_lamp = lamp_pins[1];
  assign drive.position      = step_position;
  assign drive.motion_mode   = mode_reg;

  a_stall_blocks_tick: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drive.ready) |-> !tick.ready)
    else $error("tick accepted while drive beat stalled");

  a_coil_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(coil_reg))
    else $error("coil pattern not one-hot");

  a_stop_lamps_low: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && mode_next == MODE_STOP) |=> (lamp_pins == 2'b00))
    else $error("lamps lit in stop");

  a_position_hold: assert property (@(posedge clk) disable iff (rst)
    (!tick_acc && !(cfg_we && cfg_index == REG_FULL_STEPS)) |=> $stable(step_position))
    else $error("position moved without tick or write");

  a_step_one: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && step_due && mode_next == MODE_FWD && !cfg_we)
      |=> (step_position == $past(step_position) + POS_W'(1)))
    else $error("forward step did not advance position by one");

endmodule

// File: sim/gate_stepper_debounce_controller_core_test.sv
module gate_stepper_debounce_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gsdc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(3);

  typedef struct packed {
    logic               a;
    logic               b;
    logic [SPEED_W-1:0] speed;
  } tick_t;

  typedef struct packed {
    logic [3:0]       coil;
    logic             fwd_lamp;
    logic             back_lamp;
    logic [POS_W-1:0] pos;
    mode_t            mode;
  } drive_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_CHECK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    tick_t                  t;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    drive_t                 want;
  } plan_row_t;

  localparam drive_t AT_RESET = '{4'd0, 1'b0, 1'b0, POS_RESET, MODE_STOP};
  localparam drive_t ANY      = '0;

  localparam int DIRECTED_ROWS = 30;
  localparam plan_row_t PLAN [DIRECTED_ROWS] = '{
    '{ROW_CHECK, '{1'b0, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    AT_RESET},
    '{ROW_CHECK, '{1'b1, 1'b1, 10'd1023}, REG_DEBOUNCE_DELAY, 16'd0,    AT_RESET},
    '{ROW_CHECK, '{1'b0, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    AT_RESET},
    '{ROW_WRITE, '0,                      REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_WRITE, '0,                      REG_FULL_STEPS,     16'hFFFF, ANY},
    '{ROW_TICK,  '{1'b1, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b1, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b1, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b1, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b1, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b0, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd1023}, REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_WRITE, '0,                      REG_FULL_STEPS,     16'd1,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_TICK,  '{1'b0, 1'b1, 10'd0},    REG_DEBOUNCE_DELAY, 16'd0,    ANY},
    '{ROW_WRITE, '0,                      REG_SPARE,          16'hFFFF, ANY},
    '{ROW_TICK,  '{1'b0, 1'b0, 10'd512},  REG_DEBOUNCE_DELAY, 16'd0,    ANY}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  gsdc_tick_if  tick_ch ();
  gsdc_drive_if drive_ch ();

  gate_stepper_debounce_controller_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .drive     (drive_ch)
  );

  // controller state as predicted
  logic [DELAY_W-1:0] delay_cfg;
  logic [STEPS_W-1:0] steps_cfg;
  logic [TIME_W-1:0]  ms_now;
  logic [TIME_W-1:0]  chg_a;
  logic [TIME_W-1:0]  chg_b;
  logic [TIME_W-1:0]  step_mark;
  logic               raw_a;
  logic               raw_b;
  logic               deb_a;
  logic               deb_b;
  mode_t              mode_q;
  logic [1:0]         phase_q;
  logic [POS_W-1:0]   pos_q;
  logic [3:0]         coil_q;
  logic [1:0]         toggles_q;
  logic [1:0]         pins_q;

  drive_t drive_due [$];
  int     sender_idle;
  int     recv_stall;
  int     mismatches = 0;
  int     ticks_sent;
  int     beats_checked = 0;
  int     steps_taken;
  int     travel_blocked;
  int     mode_changes;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    drive_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    drive_t want;
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      if (drive_due.size() == 0) begin
        $error("drive beat with no tick outstanding");
        mismatches++;
      end else begin
        want = drive_due.pop_front();
        beats_checked++;
        if (drive_ch.coil_pattern !== want.coil) begin
          $error("coil_pattern: expected %0h, got %0h", want.coil, drive_ch.coil_pattern);
          mismatches++;
        end
        if (drive_ch.forward_lamp !== want.fwd_lamp) begin
          $error("forward_lamp: expected %0d, got %0d", want.fwd_lamp, drive_ch.forward_lamp);
          mismatches++;
        end
        if (drive_ch.backward_lamp !== want.back_lamp) begin
          $error("backward_lamp: expected %0d, got %0d", want.back_lamp,
                 drive_ch.backward_lamp);
          mismatches++;
        end
        if (drive_ch.position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, drive_ch.position);
          mismatches++;
        end
        if (drive_ch.motion_mode !== want.mode) begin
          $error("motion_mode: expected %0d, got %0d", want.mode, drive_ch.motion_mode);
          mismatches++;
        end
      end
    end
  end

  function automatic bit settle_button(input logic raw, inout logic last, inout logic stable,
                                       inout logic [TIME_W-1:0] changed);
    bit rose;
    rose = 1'b0;
    if (raw != last) changed = ms_now;
    if ((ms_now - changed) > TIME_W'(delay_cfg) && raw != stable) begin
      stable = raw;
      rose   = raw;
    end
    last = raw;
    return rose;
  endfunction

  function automatic drive_t next_drive(input tick_t t);
    int                lvl;
    bit                pa;
    bit                pb;
    bit                move;
    mode_t             prev;
    logic [TIME_W-1:0] interval;
    drive_t            d;
    ms_now = ms_now + 1'b1;
    pa = settle_button(t.a, raw_a, deb_a, chg_a);
    pb = settle_button(t.b, raw_b, deb_b, chg_b);
    lvl = (mode_q == MODE_FWD) ? -1 : (mode_q == MODE_BACK) ? 1 : 0;
    lvl = lvl - int'(pa) + int'(pb);
    prev = mode_q;
    if (lvl < 0) mode_q = MODE_FWD;
    else if (lvl > 0) mode_q = MODE_BACK;
    else mode_q = MODE_STOP;
    if (mode_q != prev) mode_changes++;
    interval = TIME_W'(5 + int'(t.speed) * 50 / 1024);
    move = 1'b0;
    if (mode_q == MODE_FWD) move = (pos_q <= {1'b0, steps_cfg});
    else if (mode_q == MODE_BACK) move = (pos_q != '0);
    else pins_q = 2'b00;
    if (mode_q != MODE_STOP && !move) travel_blocked++;
    if (move && (ms_now - step_mark) >= interval) begin
      step_mark = ms_now;
      phase_q   = phase_q + 1'b1;
      steps_taken++;
      if (mode_q == MODE_FWD) begin
        pos_q        = pos_q + 1'b1;
        toggles_q[0] = ~toggles_q[0];
        pins_q[0]    = toggles_q[0];
        coil_q       = 4'b0001 << phase_q;
      end else begin
        pos_q        = pos_q - 1'b1;
        toggles_q[1] = ~toggles_q[1];
        pins_q[1]    = toggles_q[1];
        coil_q       = 4'b1000 >> phase_q;
      end
    end
    d.coil      = coil_q;
    d.fwd_lamp  = pins_q[0];
    d.back_lamp = pins_q[1];
    d.pos       = pos_q;
    d.mode      = mode_q;
    return d;
  endfunction

  // called at a falling edge, returns at a falling edge with valid left high
  task automatic send_tick(input tick_t t, input bit typed, input drive_t want);
    drive_t d;
    while ($urandom_range(99) < sender_idle) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid          <= 1'b1;
    tick_ch.button_a_level <= t.a;
    tick_ch.button_b_level <= t.b;
    tick_ch.speed_sample   <= t.speed;
    forever begin
      @(posedge clk);
      if (tick_ch.ready) break;
    end
    d = next_drive(t);
    drive_due.push_back(typed ? want : d);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (drive_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE_DELAY: delay_cfg = data;
      REG_FULL_STEPS: begin
        steps_cfg = data[STEPS_W-1:0];
        pos_q     = {1'b0, data[STEPS_W-1:0]};
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [DELAY_W-1:0] delay, input logic [STEPS_W-1:0] steps);
    wait_drained();
    write_reg(REG_DEBOUNCE_DELAY, delay);
    write_reg(REG_FULL_STEPS, {4'($urandom), steps});
  endtask

  function automatic int pick_hold();
    if (delay_cfg > 16'd64) return $urandom_range(1, 40);
    if ($urandom_range(99) < 25) return $urandom_range(1, 2);
    return int'(delay_cfg) + 2 + $urandom_range(0, 6);
  endfunction

  // press/release runs that pass a debounce of up to 64, mixed with bounces
  task automatic drive_random(input int n);
    tick_t t;
    int    hold_a;
    int    hold_b;
    int    pick;
    t      = '0;
    t.a    = 1'($urandom);
    t.b    = 1'($urandom);
    hold_a = $urandom_range(0, 4);
    hold_b = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      if (hold_a <= 0) begin
        t.a    = ~t.a;
        hold_a = pick_hold();
      end
      if (hold_b <= 0) begin
        t.b    = ~t.b;
        hold_b = pick_hold();
      end
      pick = $urandom_range(99);
      if (pick < 60) t.speed = SPEED_W'($urandom_range(0, 150));
      else if (pick < 85) t.speed = SPEED_W'($urandom);
      else t.speed = pick[0] ? '1 : '0;
      send_tick(t, 1'b0, ANY);
      hold_a--;
      hold_b--;
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    tick_ch.valid          = 1'b0;
    tick_ch.button_a_level = 1'b0;
    tick_ch.button_b_level = 1'b0;
    tick_ch.speed_sample   = '0;
    sender_idle            = 0;
    recv_stall             = 0;
    ticks_sent             = 0;
    steps_taken            = 0;
    travel_blocked         = 0;
    mode_changes           = 0;
    delay_cfg              = DELAY_RESET;
    steps_cfg              = STEPS_RESET;
    ms_now                 = '0;
    chg_a                  = '0;
    chg_b                  = '0;
    step_mark              = '0;
    raw_a                  = 1'b0;
    raw_b                  = 1'b0;
    deb_a                  = 1'b0;
    deb_b                  = 1'b0;
    mode_q                 = MODE_STOP;
    phase_q                = PHASE_RESET;
    pos_q                  = POS_RESET;
    coil_q                 = 4'd0;
    toggles_q              = 2'b00;
    pins_q                 = 2'b00;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      case (PLAN[i].kind)
        ROW_WRITE: begin
          wait_drained();
          write_reg(PLAN[i].reg_idx, PLAN[i].reg_data);
        end
        ROW_CHECK: send_tick(PLAN[i].t, 1'b1, PLAN[i].want);
        default:   send_tick(PLAN[i].t, 1'b0, ANY);
      endcase
    end

    sender_idle = 0;
    recv_stall  = 0;
    reconfigure(16'd0, 12'd3);
    drive_random(70);

    sender_idle = 74;
    recv_stall  = 0;
    reconfigure(16'd2, 12'd1);
    drive_random(65);

    sender_idle = 0;
    recv_stall  = 74;
    reconfigure(16'd1, 12'd4095);
    drive_random(65);

    sender_idle = 22;
    recv_stall  = 22;
    reconfigure(16'd3, 12'd6);
    drive_random(65);

    sender_idle = 0;
    recv_stall  = 0;
    reconfigure(16'hFFFF, STEPS_W'($urandom_range(1, 4095)));
    drive_random(60);

    sender_idle = 22;
    recv_stall  = 22;
    reconfigure(DELAY_W'($urandom_range(0, 4)), STEPS_W'($urandom_range(1, 8)));
    drive_random(75);

    wait_drained();
    $display("covered %0d ticks, %0d drive beats checked, %0d steps, %0d mode changes,",
             ticks_sent, beats_checked, steps_taken, mode_changes);
    $display("%0d ticks held at end of travel, debounce 0..65535 and travel 1..4095",
             travel_blocked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/gsdc_pkg.sv
rtl/core/gsdc_tick_if.sv
rtl/core/gsdc_drive_if.sv
rtl/core/gate_stepper_debounce_controller_core.sv
sim/gate_stepper_debounce_controller_core_test.sv
